// ----- rtl/lrs_pkg.sv -----
// ---------------------------------------------------------------------------
// lrs_pkg
// Shared types and fixed widths for the line raster stepper.
// ---------------------------------------------------------------------------
`default_nettype none

package lrs_pkg;

    localparam int COORD_W = 6;
    localparam int DELTA_W = COORD_W + 1;
    localparam int ERR_W   = COORD_W + 3;
    localparam int E2_W    = ERR_W + 1;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } req_t;

    typedef struct packed {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic               last_point;
    } point_t;

    // one prepared line, handed from the front end to the stepper
    typedef struct packed {
        logic [COORD_W-1:0]        cursor_x;
        logic [COORD_W-1:0]        cursor_y;
        logic [COORD_W-1:0]        target_x;
        logic [COORD_W-1:0]        target_y;
        logic [DELTA_W-1:0]        abs_delta_x;
        logic signed [DELTA_W-1:0] neg_delta_y;
        logic signed [ERR_W-1:0]   error_term;
        logic                      dir_x_negative;
        logic                      dir_y_negative;
    } job_t;

endpackage

`default_nettype wire

// ----- rtl/lrs_front.sv -----
// ---------------------------------------------------------------------------
// lrs_front
// Masks a line request to the grid and works out deltas, step directions
// and the starting error term.
// ---------------------------------------------------------------------------
`default_nettype none

module lrs_front #(
    parameter int COORD_BITS = 6
) (
    input  wire lrs_pkg::req_t req,
    output lrs_pkg::job_t      job
);

    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] tx;
    logic [COORD_BITS-1:0] ty;
    logic                  x_up;
    logic                  y_up;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic signed [lrs_pkg::DELTA_W-1:0] ndy;

    always_comb
    begin
        sx   = req.start_x[COORD_BITS-1:0];
        sy   = req.start_y[COORD_BITS-1:0];
        tx   = req.end_x[COORD_BITS-1:0];
        ty   = req.end_y[COORD_BITS-1:0];
        x_up = sx < tx;
        y_up = sy < ty;
        adx  = x_up ? (tx - sx) : (sx - tx);
        ady  = y_up ? (ty - sy) : (sy - ty);
        ndy  = -$signed(lrs_pkg::DELTA_W'(ady));

        job.cursor_x       = lrs_pkg::COORD_W'(sx);
        job.cursor_y       = lrs_pkg::COORD_W'(sy);
        job.target_x       = lrs_pkg::COORD_W'(tx);
        job.target_y       = lrs_pkg::COORD_W'(ty);
        job.abs_delta_x    = lrs_pkg::DELTA_W'(adx);
        job.neg_delta_y    = ndy;
        job.error_term     = $signed(lrs_pkg::ERR_W'(adx)) + lrs_pkg::ERR_W'(ndy);
        job.dir_x_negative = ~x_up;
        job.dir_y_negative = ~y_up;
    end

endmodule

`default_nettype wire

// ----- rtl/lrs_queue.sv -----
// ---------------------------------------------------------------------------
// lrs_queue
// Two-entry queue of prepared lines between the front end and the stepper.
// ---------------------------------------------------------------------------
`default_nettype none

module lrs_queue (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  wire lrs_pkg::job_t push_job,
    input  wire                pop,
    output lrs_pkg::job_t      pop_job,
    output logic               full,
    output logic               empty
);

    lrs_pkg::job_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full    = fill_reg == 2'd2;
    assign empty   = fill_reg == 2'd0;
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lrs_stepper.sv -----
// ---------------------------------------------------------------------------
// lrs_stepper
// Error-term line walker: takes a prepared line and emits one cell per
// cycle, flagging the end cell.
// ---------------------------------------------------------------------------
`default_nettype none

module lrs_stepper #(
    parameter int COORD_BITS = 6
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                job_ready,
    input  wire lrs_pkg::job_t job,
    output logic               job_pop,
    output lrs_pkg::point_t    point,
    output logic               point_strobe
);

    localparam int ERR_W   = lrs_pkg::ERR_W;
    localparam int E2_W    = lrs_pkg::E2_W;
    localparam int DELTA_W = lrs_pkg::DELTA_W;

    logic                      active_reg;
    logic                      active_next;
    logic [COORD_BITS-1:0]     cx_reg;
    logic [COORD_BITS-1:0]     cx_next;
    logic [COORD_BITS-1:0]     cy_reg;
    logic [COORD_BITS-1:0]     cy_next;
    logic [COORD_BITS-1:0]     tx_reg;
    logic [COORD_BITS-1:0]     ty_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [ERR_W-1:0]   err_next;
    logic [DELTA_W-1:0]        adx_reg;
    logic signed [DELTA_W-1:0] ndy_reg;
    logic                      xneg_reg;
    logic                      yneg_reg;
    logic [COORD_BITS-1:0]     count_reg;
    logic [COORD_BITS-1:0]     count_next;
    lrs_pkg::point_t           point_reg;
    lrs_pkg::point_t           point_next;
    logic                      strobe_reg;
    logic                      strobe_next;

    logic signed [E2_W-1:0]  e2;
    logic signed [E2_W-1:0]  ndy_e;
    logic signed [E2_W-1:0]  adx_e;
    logic signed [ERR_W-1:0] ndy_s;
    logic signed [ERR_W-1:0] adx_s;
    logic signed [ERR_W-1:0] err_mid;
    logic [COORD_BITS-1:0]   cx_mid;
    logic                    x_step;
    logic                    y_step;
    logic                    done;

    assign job_pop      = ~active_reg & job_ready;
    assign point        = point_reg;
    assign point_strobe = strobe_reg;

    always_comb
    begin
        e2      = E2_W'(err_reg) <<< 1;
        ndy_e   = E2_W'(ndy_reg);
        adx_e   = E2_W'(adx_reg);
        ndy_s   = ERR_W'(ndy_reg);
        adx_s   = ERR_W'(adx_reg);
        x_step  = e2 >= ndy_e;
        y_step  = e2 <= adx_e;
        done    = 1'b0;
        err_mid = err_reg;
        cx_mid  = cx_reg;
        cy_next = cy_reg;

        if (x_step)
        begin
            if (cx_reg == tx_reg)
            begin
                done = 1'b1;
            end
            else
            begin
                err_mid = err_reg + ndy_s;
                cx_mid  = xneg_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;
            end
        end
        err_next = err_mid;
        if (!done && y_step)
        begin
            if (cy_reg == ty_reg)
            begin
                done = 1'b1;
            end
            else
            begin
                err_next = err_mid + adx_s;
                cy_next  = yneg_reg ? cy_reg - 1'b1 : cy_reg + 1'b1;
            end
        end
        // runaway guard at the grid's point limit
        if (&count_reg)
        begin
            done = 1'b1;
        end
        cx_next    = cx_mid;
        count_next = count_reg + 1'b1;

        point_next.point_x    = done ? lrs_pkg::COORD_W'(cx_next) : lrs_pkg::COORD_W'(cx_reg);
        point_next.point_y    = done ? lrs_pkg::COORD_W'(cy_next) : lrs_pkg::COORD_W'(cy_reg);
        point_next.last_point = done;
        strobe_next           = active_reg;
        active_next           = active_reg ? ~done : job_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        point_reg <= point_next;
        if (job_pop)
        begin
            cx_reg    <= job.cursor_x[COORD_BITS-1:0];
            cy_reg    <= job.cursor_y[COORD_BITS-1:0];
            tx_reg    <= job.target_x[COORD_BITS-1:0];
            ty_reg    <= job.target_y[COORD_BITS-1:0];
            err_reg   <= job.error_term;
            adx_reg   <= job.abs_delta_x;
            ndy_reg   <= job.neg_delta_y;
            xneg_reg  <= job.dir_x_negative;
            yneg_reg  <= job.dir_y_negative;
            count_reg <= '0;
        end
        else if (active_reg)
        begin
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            err_reg   <= err_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/line_raster_stepper_core.sv -----
// ---------------------------------------------------------------------------
// line_raster_stepper_core
// Bresenham line rasterizer: one line request in, every cell of the line
// out in order, one cell per cycle, end cell flagged.
// ---------------------------------------------------------------------------
//   channel   ports                   handshake
//   request   start, busy, req        transfer when start && !busy
//   result    point_strobe, point     transfer on each cycle strobe is high
//
// a line of n cells gives n results on back-to-back cycles; the stepper
// walker emits one cell per cycle and loads the next line while idle
// between lines. a request passes the queue, walker and point registers.
// a two-entry line queue sits between request prep and the walker; busy is
// high while it is full. results cannot be stalled.
// reset clears the queue and the walker; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module line_raster_stepper_core #(
    parameter int COORD_BITS = 6
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    output logic               busy,
    input  wire lrs_pkg::req_t req,
    output lrs_pkg::point_t    point,
    output logic               point_strobe
);

    lrs_pkg::job_t front_job;
    lrs_pkg::job_t queue_job;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;

    assign busy = q_full;

    lrs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .req (req),
        .job (front_job)
    );

    lrs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (start & ~q_full),
        .push_job (front_job),
        .pop      (q_pop),
        .pop_job  (queue_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    lrs_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_ready    (~q_empty),
        .job          (queue_job),
        .job_pop      (q_pop),
        .point        (point),
        .point_strobe (point_strobe)
    );

endmodule

`default_nettype wire
